FILE: hdl/hrd_pkg.sv
`timescale 1ns / 1ps

package hrd_pkg;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KEY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TYPE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

    localparam logic [ERR_W-1:0] ERR_MAGIC   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_VERSION = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH  = 2'd2;

    localparam logic [15:0] SUPPORTED_VERSION = 16'd1;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h44, 8'h58, 8'h31};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic [15:0]       version;
        logic [ERR_W-1:0]  err_code;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result item;
    } t_push;

    typedef struct packed {
        logic    empty;
        logic    full;
        t_result head;
    } t_qstat;

endpackage

FILE: hdl/handshake_record_deframer.sv
`timescale 1ns / 1ps

// handshake_record_deframer
// input channel: one received byte per transfer on i_in_valid / o_in_stall /
// i_in_byte. the stream opens with the four magic bytes, a 16-bit version
// and KEY_BYTES key bytes, then carries length-prefixed records.
// output channel: one result per transfer on o_out_valid / i_out_stall with
// o_kind, o_data, o_version, o_err_code and o_last.
// config: i_cfg_wr_en writes i_cfg_wr_data into the maximum record length,
// to be done while the block is idle.
// throughput: one byte per cycle; the front decoder takes a byte every
// cycle while the four-entry result queue has room.
// a result enters the queue as its byte is taken, then the output register.
// when the receiver stalls the output register holds and the queue fills;
// o_in_stall rises once the queue is full.
// reset: i_rst_n low returns to waiting for magic, clears the queue and the
// output valid and sets the maximum record length to 65536. after an error
// result every byte is taken and dropped until reset.

module handshake_record_deframer #(
    parameter int unsigned KEY_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_cfg_wr_en,
    input  logic [31:0]                i_cfg_wr_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [hrd_pkg::KIND_W-1:0] o_kind,
    output logic [7:0]                 o_data,
    output logic [15:0]                o_version,
    output logic [hrd_pkg::ERR_W-1:0]  o_err_code,
    output logic                       o_last
);
    import hrd_pkg::*;

    t_push  push;
    t_qstat stat;
    logic   pop;

    hrd_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (stat.full),
        .o_push        (push)
    );

    hrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (stat)
    );

    hrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stat       (stat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_version    (o_version),
        .o_err_code   (o_err_code),
        .o_last       (o_last)
    );

endmodule

FILE: hdl/hrd_front.sv
`timescale 1ns / 1ps

module hrd_front #(
    parameter int unsigned KEY_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_q_full,
    output hrd_pkg::t_push o_push
);
    import hrd_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_VERSION, PH_KEY, PH_LENGTH, PH_TYPE, PH_PAYLOAD, PH_HALT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_len, n_len;
    logic        r_match, n_match;
    logic [7:0]  r_ver_hi, n_ver_hi;
    logic [31:0] r_max;

    logic        accept;
    logic        match_now;
    logic [15:0] ver_now;
    logic [31:0] len_now;
    t_push       push;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign match_now  = r_match && (i_in_byte == MAGIC[r_count[1:0]]);
    assign ver_now    = {r_ver_hi, i_in_byte};
    assign len_now    = {r_len[23:0], i_in_byte};

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_len    = r_len;
        n_match  = r_match;
        n_ver_hi = r_ver_hi;
        push     = '0;
        if (accept) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    n_match = match_now;
                    if (r_count[1:0] == 2'd3) begin
                        n_count = '0;
                        if (match_now) begin
                            n_phase = PH_VERSION;
                        end else begin
                            n_phase             = PH_HALT;
                            push.push           = 1'b1;
                            push.item.kind      = KIND_ERROR;
                            push.item.err_code  = ERR_MAGIC;
                        end
                    end else begin
                        n_count = r_count + 32'd1;
                    end
                end
                PH_VERSION: begin
                    if (r_count == '0) begin
                        n_ver_hi = i_in_byte;
                        n_count  = 32'd1;
                    end else begin
                        n_count           = '0;
                        push.push         = 1'b1;
                        push.item.version = ver_now;
                        if (ver_now == SUPPORTED_VERSION) begin
                            n_phase        = PH_KEY;
                            push.item.kind = KIND_VERSION;
                        end else begin
                            n_phase            = PH_HALT;
                            push.item.kind     = KIND_ERROR;
                            push.item.err_code = ERR_VERSION;
                        end
                    end
                end
                PH_KEY: begin
                    push.push      = 1'b1;
                    push.item.kind = KIND_KEY;
                    push.item.data = i_in_byte;
                    if (r_count == 32'(KEY_BYTES - 1)) begin
                        push.item.last = 1'b1;
                        n_count        = '0;
                        n_len          = '0;
                        n_phase        = PH_LENGTH;
                    end else begin
                        n_count = r_count + 32'd1;
                    end
                end
                PH_LENGTH: begin
                    n_len = len_now;
                    if (r_count[1:0] == 2'd3) begin
                        n_count = '0;
                        if (len_now == '0 || len_now > r_max) begin
                            n_phase            = PH_HALT;
                            push.push          = 1'b1;
                            push.item.kind     = KIND_ERROR;
                            push.item.err_code = ERR_LENGTH;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end else begin
                        n_count = r_count + 32'd1;
                    end
                end
                PH_TYPE: begin
                    push.push      = 1'b1;
                    push.item.kind = KIND_TYPE;
                    push.item.data = i_in_byte;
                    n_len          = '0;
                    if (r_len == 32'd1) begin
                        push.item.last = 1'b1;
                        n_phase        = PH_LENGTH;
                    end else begin
                        n_count = r_len - 32'd1;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    push.push      = 1'b1;
                    push.item.kind = KIND_PAYLOAD;
                    push.item.data = i_in_byte;
                    if (r_count <= 32'd1) begin
                        push.item.last = 1'b1;
                        n_count        = '0;
                        n_len          = '0;
                        n_phase        = PH_LENGTH;
                    end else begin
                        n_count = r_count - 32'd1;
                    end
                end
                PH_HALT: begin
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_count  <= '0;
            r_len    <= '0;
            r_match  <= 1'b1;
            r_ver_hi <= '0;
            r_max    <= MAX_PAYLOAD_RESET;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_match  <= n_match;
            r_ver_hi <= n_ver_hi;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

    assign o_push = push;

endmodule

FILE: hdl/hrd_queue.sv
`timescale 1ns / 1ps

module hrd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrd_pkg::t_push  i_push,
    input  logic            i_pop,
    output hrd_pkg::t_qstat o_stat
);
    import hrd_pkg::*;

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.head  = r_mem[r_rd_ptr];

    assign do_push = i_push.push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/hrd_back.sv
`timescale 1ns / 1ps

module hrd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hrd_pkg::t_qstat         i_stat,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [hrd_pkg::KIND_W-1:0] o_kind,
    output logic [7:0]              o_data,
    output logic [15:0]             o_version,
    output logic [hrd_pkg::ERR_W-1:0]  o_err_code,
    output logic                    o_last
);
    import hrd_pkg::*;

    logic    r_valid;
    t_result r_item;
    logic    load;

    // output register refills from a non-empty queue whenever it is empty or its transfer completes
    assign load  = !i_stat.empty && (!r_valid || !i_out_stall);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_stat.head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_item.kind;
    assign o_data      = r_item.data;
    assign o_version   = r_item.version;
    assign o_err_code  = r_item.err_code;
    assign o_last      = r_item.last;

endmodule

FILE: sim/hrd_checker.sv
`timescale 1ns / 1ps

module hrd_checker #(
    parameter int unsigned KEY_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_cfg_wr_en,
    input  logic [31:0]                i_cfg_wr_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [hrd_pkg::KIND_W-1:0] i_kind,
    input  logic [7:0]                 i_data,
    input  logic [15:0]                i_version,
    input  logic [hrd_pkg::ERR_W-1:0]  i_err_code,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    import hrd_pkg::*;

    typedef enum logic [2:0] {
        ST_MAGIC,
        ST_VERSION,
        ST_KEY,
        ST_LENGTH,
        ST_TYPE,
        ST_PAYLOAD,
        ST_HALT
    } t_stage;

    t_stage      stage       = ST_MAGIC;
    logic [31:0] field_count = '0;
    logic [31:0] len_acc     = '0;
    logic        magic_ok    = 1'b1;
    logic [7:0]  ver_hi      = '0;
    logic [31:0] max_len     = MAX_PAYLOAD_RESET;
    t_result     expected_results[$];
    int          fails       = 0;

    function automatic t_result make_result(input logic [KIND_W-1:0] kind,
                                            input logic [7:0] data,
                                            input logic [15:0] ver,
                                            input logic [ERR_W-1:0] err,
                                            input logic last);
        t_result r;
        r.kind     = kind;
        r.data     = data;
        r.version  = ver;
        r.err_code = err;
        r.last     = last;
        return r;
    endfunction

    function automatic string fmt(input t_result r);
        return $sformatf("kind=%0d data=%02h version=%04h err_code=%0d last=%0b",
                         r.kind, r.data, r.version, r.err_code, r.last);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] ver;
        logic        fin;
        case (stage)
            ST_MAGIC: begin
                if (b != MAGIC[field_count[1:0]])
                    magic_ok = 1'b0;
                field_count = field_count + 1;
                if (field_count == 4) begin
                    field_count = '0;
                    if (!magic_ok) begin
                        stage = ST_HALT;
                        expected_results.push_back(
                            make_result(KIND_ERROR, 8'h00, 16'h0000, ERR_MAGIC, 1'b0));
                    end else begin
                        stage = ST_VERSION;
                    end
                end
            end
            ST_VERSION: begin
                if (field_count == 0) begin
                    ver_hi      = b;
                    field_count = 1;
                end else begin
                    ver         = {ver_hi, b};
                    field_count = '0;
                    if (ver != SUPPORTED_VERSION) begin
                        stage = ST_HALT;
                        expected_results.push_back(
                            make_result(KIND_ERROR, 8'h00, ver, ERR_VERSION, 1'b0));
                    end else begin
                        stage = ST_KEY;
                        expected_results.push_back(
                            make_result(KIND_VERSION, 8'h00, ver, ERR_MAGIC, 1'b0));
                    end
                end
            end
            ST_KEY: begin
                fin         = (field_count + 1 >= KEY_BYTES);
                field_count = field_count + 1;
                if (fin) begin
                    field_count = '0;
                    len_acc     = '0;
                    stage       = ST_LENGTH;
                end
                expected_results.push_back(make_result(KIND_KEY, b, 16'h0000, ERR_MAGIC, fin));
            end
            ST_LENGTH: begin
                len_acc     = {len_acc[23:0], b};
                field_count = field_count + 1;
                if (field_count == 4) begin
                    field_count = '0;
                    if (len_acc == 0 || len_acc > max_len) begin
                        stage = ST_HALT;
                        expected_results.push_back(
                            make_result(KIND_ERROR, 8'h00, 16'h0000, ERR_LENGTH, 1'b0));
                    end else begin
                        stage = ST_TYPE;
                    end
                end
            end
            ST_TYPE: begin
                if (len_acc == 1) begin
                    len_acc = '0;
                    stage   = ST_LENGTH;
                    expected_results.push_back(
                        make_result(KIND_TYPE, b, 16'h0000, ERR_MAGIC, 1'b1));
                end else begin
                    field_count = len_acc - 1;
                    len_acc     = '0;
                    stage       = ST_PAYLOAD;
                    expected_results.push_back(
                        make_result(KIND_TYPE, b, 16'h0000, ERR_MAGIC, 1'b0));
                end
            end
            ST_PAYLOAD: begin
                fin = (field_count <= 1);
                if (fin) begin
                    field_count = '0;
                    len_acc     = '0;
                    stage       = ST_LENGTH;
                end else begin
                    field_count = field_count - 1;
                end
                expected_results.push_back(make_result(KIND_PAYLOAD, b, 16'h0000, ERR_MAGIC, fin));
            end
            default: begin
                stage = ST_HALT;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            stage       = ST_MAGIC;
            field_count = '0;
            len_acc     = '0;
            magic_ok    = 1'b1;
            ver_hi      = '0;
            max_len     = MAX_PAYLOAD_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en)
                max_len = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_in_byte);
            if (i_out_valid && !i_out_stall) begin
                got.kind     = i_kind;
                got.data     = i_data;
                got.version  = i_version;
                got.err_code = i_err_code;
                got.last     = i_last;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with nothing expected: %s", $realtime, fmt(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.version !== want.version ||
                        got.err_code !== want.err_code || got.last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt(want), fmt(got));
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tb_handshake_record_deframer.sv
`timescale 1ns / 1ps

module tb_handshake_record_deframer;
    import hrd_pkg::*;

    localparam int unsigned KEY_BYTES   = 32;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 8;

    typedef enum int {
        RUN_BAD_MAGIC,
        RUN_BAD_VERSION,
        RUN_RECORDS
    } t_run;

    typedef enum int {
        END_ZERO_LENGTH,
        END_OVER_MAX,
        END_ZERO_MAX
    } t_ending;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [7:0]          in_byte     = '0;
    logic                cfg_wr_en   = 1'b0;
    logic [31:0]         cfg_wr_data = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [7:0]          data;
    logic [15:0]         version;
    logic [ERR_W-1:0]    err_code;
    logic                last;

    int                  fail_count;
    int                  pending;
    int unsigned         cycles         = 0;
    int unsigned         bytes_sent     = 0;
    int unsigned         src_idle_pct   = 0;
    int unsigned         sink_stall_pct = 0;
    logic [31:0]         cur_max        = MAX_PAYLOAD_RESET;
    logic                pressure_req   = 1'b0;
    logic                sink_hold      = 1'b0;

    always #5 clk = ~clk;

    handshake_record_deframer #(
        .KEY_BYTES(KEY_BYTES)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_byte     (in_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (kind),
        .o_data        (data),
        .o_version     (version),
        .o_err_code    (err_code),
        .o_last        (last)
    );

    hrd_checker #(
        .KEY_BYTES(KEY_BYTES)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_byte     (in_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_kind        (kind),
        .i_data        (data),
        .i_version     (version),
        .i_err_code    (err_code),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= sink_hold || ($urandom_range(99) < sink_stall_pct);
        end
    end

    // long receiver hold-off so the result queue fills and the input stalls
    initial begin
        wait (pressure_req);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL handshake_record_deframer");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        bytes_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_max(input logic [31:0] value);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_max      = value;
    endtask

    task automatic send_length(input logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            send_byte(len[i*8 +: 8]);
    endtask

    task automatic send_record(input logic [31:0] len, input logic [7:0] type_byte);
        send_length(len);
        send_byte(type_byte);
        repeat (len - 1) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_handshake();
        for (int i = 0; i < 4; i++)
            send_byte(MAGIC[i]);
        send_byte(SUPPORTED_VERSION[15:8]);
        send_byte(SUPPORTED_VERSION[7:0]);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_noise(KEY_BYTES - 2);
    endtask

    function automatic logic [31:0] pick_length();
        logic [31:0] cap;
        int unsigned r;
        cap = (cur_max > 200) ? 32'd200 : cur_max;
        r   = $urandom_range(99);
        if (r < 15)
            return 1;
        if (r < 25)
            return cap;
        if (r < 90)
            return $urandom_range((cap < 16) ? cap : 16, 1);
        return $urandom_range(cap, 1);
    endfunction

    task automatic send_records_until(input int unsigned target);
        while (bytes_sent < target)
            send_record(pick_length(), 8'($urandom_range(255)));
    endtask

    initial begin
        t_run        mode;
        t_ending     ending;
        int unsigned pick;
        int unsigned bad_pos;
        logic [7:0]  b;
        logic [15:0] bad_ver;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        pick = $urandom_range(9);
        mode = (pick == 0) ? RUN_BAD_MAGIC : (pick == 1) ? RUN_BAD_VERSION : RUN_RECORDS;

        case (mode)
            RUN_BAD_MAGIC: begin
                write_max($urandom);
                bad_pos = $urandom_range(3);
                for (int i = 0; i < 4; i++) begin
                    b = MAGIC[i];
                    if (i == bad_pos)
                        b = b ^ 8'($urandom_range(255, 1));
                    send_byte(b);
                end
                send_noise(1544);
            end
            RUN_BAD_VERSION: begin
                write_max($urandom);
                case ($urandom_range(3))
                    0: bad_ver = 16'h0000;
                    1: bad_ver = 16'hFFFF;
                    2: bad_ver = 16'h0100;
                    default: bad_ver = 16'($urandom_range(65535, 2));
                endcase
                for (int i = 0; i < 4; i++)
                    send_byte(MAGIC[i]);
                send_byte(bad_ver[15:8]);
                send_byte(bad_ver[7:0]);
                send_noise(1544);
            end
            default: begin
                // reset maximum, no idling
                send_handshake();
                send_record(1, 8'h00);
                send_record(2, 8'hFF);
                send_record(3, 8'h5A);
                send_records_until(400);

                // type-only records, sender idling
                write_max(1);
                src_idle_pct = 50;
                send_records_until(520);

                // widest maximum, receiver stalling
                write_max(32'hFFFF_FFFF);
                src_idle_pct   = 0;
                sink_stall_pct = 50;
                send_records_until(850);

                // small maximum, both sides idling
                write_max($urandom_range(40, 2));
                src_idle_pct   = 31;
                sink_stall_pct = 31;
                send_records_until(1200);

                // back to the reset value under a long receiver hold-off
                write_max(MAX_PAYLOAD_RESET);
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                pressure_req   = 1'b1;
                send_record(250, 8'($urandom_range(255)));
                send_records_until(1500);

                // one length error to finish, then bytes the halted block drops
                ending = t_ending'($urandom_range(2));
                case (ending)
                    END_ZERO_LENGTH: begin
                        send_length(0);
                    end
                    END_OVER_MAX: begin
                        send_length($urandom_range(1) ? cur_max + 1 : 32'hFFFF_FFFF);
                    end
                    default: begin
                        write_max(0);
                        send_length($urandom_range(1) ? 32'd1 : 32'($urandom));
                    end
                endcase
                send_noise(100);
            end
        endcase

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS handshake_record_deframer");
        end else begin
            $display("FAIL handshake_record_deframer");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hrd_pkg.sv
hdl/hrd_front.sv
hdl/hrd_queue.sv
hdl/hrd_back.sv
hdl/handshake_record_deframer.sv
sim/hrd_checker.sv
sim/tb_handshake_record_deframer.sv
